// ----- hw/rtl/cab_bus_poll_scheduler_top_assert.svh -----
// Assertion macros for the cab bus poll scheduler.
`ifndef CAB_BUS_POLL_SCHEDULER_TOP_ASSERT_SVH
`define CAB_BUS_POLL_SCHEDULER_TOP_ASSERT_SVH
`ifndef SYNTH
`define CBPS_ASSERT_IMPL(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define CBPS_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define CBPS_ASSERT_IMPL(label, clk, rstn, prop, msg)
`define CBPS_ASSERT_NEXT(label, clk, rstn, pre, post, msg)
`endif
`endif

// ----- hw/rtl/cbps_pkg.sv -----
`timescale 1ns / 1ps
package cbps_pkg;
    localparam int NUM_CABS_DEF = 64;
    localparam int CAB_W = 6;
    localparam int POS_W = 7;
    localparam logic [7:0] POLL_BASE = 8'h80;
    localparam logic [7:0] POLL_TICKS_RST = 8'd5;
    localparam logic [7:0] TX_LIMIT_RST = 8'd10;
    localparam logic [0:0] REG_POLL_TICKS = 1'b0;
    localparam logic [0:0] REG_TX_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        PH_STARTUP = 3'd0,
        PH_POLLING = 3'd1,
        PH_TX_WAIT = 3'd2,
        PH_KNOWN_WAIT = 3'd3,
        PH_NEW_WAIT = 3'd4
    } bus_phase_t;

    typedef enum logic [3:0] {
        OP_NONE = 4'd0,
        OP_STARTUP = 4'd1,
        OP_SELECT = 4'd2,
        OP_READ_ACT = 4'd3,
        OP_REMOVE_ACT = 4'd4,
        OP_FIND_FREE = 4'd5,
        OP_REMOVE_INACT = 4'd6,
        OP_WRITE_ACT = 4'd7,
        OP_SET_NEW = 4'd8,
        OP_NEW_TIMEOUT = 4'd9
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic [CAB_W-1:0] cab;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic [CAB_W-1:0] current_cab;
        logic new_flag;
    } dp_status_t;
endpackage

// ----- hw/rtl/cbps_datapath.sv -----
`timescale 1ns / 1ps
module cbps_datapath import cbps_pkg::*; #(
    parameter int NUM_CABS = NUM_CABS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  dp_cmd_t    cmd,
    input  logic       clr_new,
    output dp_status_t status
);
    // The two lists are memories; shifts and searches walk one entry a cycle.
    logic [CAB_W-1:0] act_mem [NUM_CABS];
    logic [CAB_W-1:0] inact_mem [NUM_CABS];
    logic [63:0] new_reg, new_next;
    logic [POS_W-1:0] apos_reg, apos_next, ipos_reg, ipos_next;
    logic [CAB_W-1:0] cur_reg, cur_next;
    logic [POS_W-1:0] idx_reg, idx_next;
    logic [CAB_W-1:0] arg_reg, arg_next;
    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001, S_SEL_RD = 8'b00000010, S_SEL_RD0 = 8'b00000100,
        S_ARD = 8'b00001000, S_SHIFT = 8'b00010000, S_FIND = 8'b00100000,
        S_CLEAR = 8'b01000000, S_SEL_ACT = 8'b10000000
    } dstate_t;
    dstate_t st_reg, st_next;
    logic shift_act_reg, shift_act_next;
    logic after_reg, after_next;
    logic [CAB_W-1:0] a_rd, i_rd;
    logic [POS_W-1:0] rd_pos;
    logic wr_a, wr_i;
    logic [CAB_W-1:0] wd_a, wd_i;
    logic [POS_W-1:0] wa_a, wa_i;
    localparam logic [POS_W-1:0] NC = POS_W'(NUM_CABS);
    localparam logic [POS_W-1:0] ONE_P = POS_W'(1);
    localparam logic [POS_W-1:0] TWO_P = POS_W'(2);
    localparam int IW = $clog2(NUM_CABS);

    always_ff @(posedge aclk) begin
        if (wr_a) act_mem[wa_a[IW-1:0]] <= wd_a;
        if (wr_i) inact_mem[wa_i[IW-1:0]] <= wd_i;
        a_rd <= act_mem[rd_pos[IW-1:0]];
        i_rd <= inact_mem[rd_pos[IW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_CLEAR;
            new_reg <= '0;
            apos_reg <= NC;
            ipos_reg <= '0;
            cur_reg <= CAB_W'(1);
            idx_reg <= '0;
            arg_reg <= '0;
            shift_act_reg <= 1'b0;
            after_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            new_reg <= new_next;
            apos_reg <= apos_next;
            ipos_reg <= ipos_next;
            cur_reg <= cur_next;
            idx_reg <= idx_next;
            arg_reg <= arg_next;
            shift_act_reg <= shift_act_next;
            after_reg <= after_next;
        end
    end

    logic [CAB_W-1:0] rdv;
    logic [POS_W-1:0] inc;
    always_comb begin
        st_next = st_reg; new_next = new_reg; apos_next = apos_reg;
        ipos_next = ipos_reg; cur_next = cur_reg; idx_next = idx_reg;
        arg_next = arg_reg; shift_act_next = shift_act_reg;
        after_next = after_reg;
        rd_pos = '0;
        wr_a = 1'b0; wr_i = 1'b0; wd_a = '0; wd_i = '0; wa_a = '0; wa_i = '0;
        rdv = '0; inc = '0;
        if (clr_new) new_next[cur_reg] = 1'b0;
        unique case (st_reg)
            S_CLEAR: begin
                wa_a = idx_reg; wd_a = '0; wr_a = 1'b1;
                wa_i = idx_reg; wr_i = 1'b1;
                wd_i = (idx_reg + ONE_P < NC) ? CAB_W'(idx_reg + ONE_P) : '0;
                idx_next = idx_reg + ONE_P;
                if (idx_reg + ONE_P >= NC) st_next = S_IDLE;
            end
            S_IDLE: begin
                unique case (cmd.op)
                    OP_STARTUP: begin
                        apos_next = '0; ipos_next = '0; cur_next = '0;
                    end
                    OP_SELECT, OP_SET_NEW: begin
                        after_next = (cmd.op == OP_SET_NEW);
                        if (cur_reg == '0) begin
                            rd_pos = ipos_reg; st_next = S_SEL_RD;
                        end else begin
                            inc = apos_reg + ONE_P;
                            if (inc >= NC) inc = '0;
                            apos_next = inc; rd_pos = inc; st_next = S_SEL_ACT;
                        end
                    end
                    OP_READ_ACT: begin
                        rd_pos = apos_reg; st_next = S_ARD;
                    end
                    OP_REMOVE_ACT: begin
                        arg_next = cmd.cab;
                        shift_act_next = 1'b1;
                        idx_next = apos_reg;
                        after_next = 1'b1;
                        if (apos_reg < NC) begin
                            rd_pos = apos_reg + ONE_P; st_next = S_SHIFT;
                        end else begin
                            idx_next = '0; rd_pos = '0; st_next = S_FIND;
                        end
                    end
                    OP_REMOVE_INACT: begin
                        arg_next = cmd.cab;
                        shift_act_next = 1'b0;
                        after_next = 1'b0;
                        idx_next = ipos_reg - ONE_P;
                        if (ipos_reg - ONE_P < NC) begin
                            rd_pos = ipos_reg; st_next = S_SHIFT;
                        end else begin
                            if (apos_reg < NC) begin
                                wa_a = apos_reg; wd_a = cmd.cab; wr_a = 1'b1;
                            end
                            apos_next = '0;
                        end
                    end
                    OP_NEW_TIMEOUT: begin
                        apos_next = '0; cur_next = '0;
                        after_next = 1'b0;
                        rd_pos = ipos_reg; st_next = S_SEL_RD;
                    end
                    default: ;
                endcase
            end
            S_SEL_RD: begin
                if (ipos_reg < NC && i_rd != '0) begin
                    cur_next = i_rd; ipos_next = ipos_reg + ONE_P;
                    if (after_reg) new_next[i_rd] = 1'b1;
                    st_next = S_IDLE;
                end else begin
                    ipos_next = '0; rd_pos = '0; st_next = S_SEL_RD0;
                end
            end
            S_SEL_RD0: begin
                cur_next = i_rd; ipos_next = ONE_P;
                if (after_reg) new_next[i_rd] = 1'b1;
                st_next = S_IDLE;
            end
            S_SEL_ACT: begin
                rdv = (apos_reg < NC) ? a_rd : '0;
                cur_next = rdv;
                if (after_reg) new_next[rdv] = 1'b1;
                st_next = S_IDLE;
            end
            S_ARD: begin
                cur_next = (apos_reg < NC) ? a_rd : '0;
                st_next = S_IDLE;
            end
            S_SHIFT: begin
                wa_a = idx_reg; wa_i = idx_reg;
                wd_a = (idx_reg + ONE_P < NC) ? a_rd : '0;
                wd_i = (idx_reg + ONE_P < NC) ? i_rd : '0;
                wr_a = shift_act_reg; wr_i = !shift_act_reg;
                idx_next = idx_reg + ONE_P;
                rd_pos = idx_reg + TWO_P;
                if (idx_reg + ONE_P >= NC) begin
                    if (shift_act_reg) begin
                        idx_next = '0; rd_pos = '0; st_next = S_FIND;
                    end else begin
                        // The removed new cab joins the active list.
                        if (apos_reg < NC) begin
                            wa_a = apos_reg; wd_a = arg_reg; wr_a = 1'b1;
                        end
                        apos_next = '0;
                        st_next = S_IDLE;
                    end
                end
            end
            S_FIND: begin
                rd_pos = idx_reg + ONE_P;
                idx_next = idx_reg + ONE_P;
                if (i_rd == '0) begin
                    wa_i = idx_reg; wd_i = arg_reg; wr_i = 1'b1;
                    st_next = S_IDLE;
                end else if (idx_reg + ONE_P >= NC) begin
                    st_next = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    assign status.busy = (st_reg != S_IDLE);
    assign status.current_cab = cur_reg;
    assign status.new_flag = new_reg[cur_reg];
endmodule

// ----- hw/rtl/cbps_controller.sv -----
`timescale 1ns / 1ps
module cbps_controller import cbps_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [65:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output dp_cmd_t     cmd,
    output logic        clr_new,
    input  dp_status_t  status
);
    typedef enum logic [4:0] {
        C_IDLE = 5'b00001, C_RUN = 5'b00010, C_WAIT = 5'b00100,
        C_OUT = 5'b01000, C_GO = 5'b10000
    } cstate_t;
    cstate_t st_reg, st_next;
    logic [7:0] pticks_reg, txlim_reg, cd_reg, cd_next, tt_reg, tt_next;
    logic [2:0] ph_reg, ph_next;
    logic [31:0] out_reg, out_next;
    logic [65:0] in_reg, in_next;
    dp_op_t q_reg [3], q_next [3];
    logic [CAB_W-1:0] qcab_reg, qcab_next;
    logic [1:0] qn_reg, qn_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pticks_reg <= POLL_TICKS_RST; txlim_reg <= TX_LIMIT_RST;
        end else if (cfg_we) begin
            if (cfg_addr == REG_POLL_TICKS) pticks_reg <= cfg_wdata;
            else txlim_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= C_IDLE; cd_reg <= '0; tt_reg <= '0; ph_reg <= PH_STARTUP;
            qn_reg <= '0;
            for (int i = 0; i < 3; i++) q_reg[i] <= OP_NONE;
        end else begin
            st_reg <= st_next; cd_reg <= cd_next; tt_reg <= tt_next;
            ph_reg <= ph_next; qn_reg <= qn_next;
            for (int i = 0; i < 3; i++) q_reg[i] <= q_next[i];
        end
        out_reg <= out_next; in_reg <= in_next; qcab_reg <= qcab_next;
    end

    logic resp, tdone;
    logic [63:0] mask;
    logic [CAB_W-1:0] cab;
    logic [7:0] dec, tinc;
    logic pv, sv, rv, act, deact;
    logic [7:0] pb;
    logic [CAB_W-1:0] sc, rc;
    always_comb begin
        st_next = st_reg; cd_next = cd_reg; tt_next = tt_reg; ph_next = ph_reg;
        out_next = out_reg; in_next = in_reg; qcab_next = qcab_reg; qn_next = qn_reg;
        for (int i = 0; i < 3; i++) q_next[i] = q_reg[i];
        cmd.op = OP_NONE; cmd.cab = qcab_reg; clr_new = 1'b0;
        resp = in_reg[0]; tdone = in_reg[1]; mask = in_reg[65:2];
        cab = status.current_cab;
        dec = cd_reg - 8'd1; tinc = tt_reg + 8'd1;
        pv = 0; sv = 0; rv = 0; act = 0; deact = 0; pb = '0; sc = '0; rc = '0;
        s_tready = (st_reg == C_IDLE) && !status.busy;
        m_tvalid = (st_reg == C_OUT);
        unique case (st_reg)
            C_IDLE: if (s_tvalid && s_tready) begin
                in_next = s_tdata; st_next = C_RUN;
            end
            C_RUN: begin
                unique case (ph_reg)
                    PH_STARTUP: begin
                        q_next[0] = OP_STARTUP; qn_next = 2'd1;
                        cd_next = 8'd1; ph_next = PH_POLLING;
                    end
                    PH_POLLING: begin
                        cd_next = dec;
                        if (dec == '0) begin
                            pv = 1; pb = POLL_BASE + {2'b00, cab};
                            if (cab == '0) begin
                                if (mask[0]) begin
                                    sv = 1; tt_next = '0; ph_next = PH_TX_WAIT;
                                end else begin
                                    q_next[0] = OP_SET_NEW; qn_next = 2'd1;
                                    cd_next = pticks_reg;
                                end
                            end else if (status.new_flag) begin
                                clr_new = 1'b1; cd_next = pticks_reg;
                                ph_next = PH_NEW_WAIT;
                            end else begin
                                cd_next = pticks_reg; ph_next = PH_KNOWN_WAIT;
                            end
                        end
                    end
                    PH_KNOWN_WAIT, PH_NEW_WAIT: begin
                        qcab_next = cab;
                        if (resp) begin
                            rv = 1; rc = cab;
                            qn_next = 2'd0;
                            if (ph_reg == PH_NEW_WAIT) begin
                                act = 1; q_next[0] = OP_REMOVE_INACT; qn_next = 2'd1;
                            end
                            if (mask[cab]) begin
                                sv = 1; sc = cab; tt_next = '0; ph_next = PH_TX_WAIT;
                            end else begin
                                q_next[qn_next] = OP_SELECT;
                                q_next[qn_next + 2'd1] = OP_READ_ACT;
                                qn_next = qn_next + 2'd2;
                                cd_next = pticks_reg; ph_next = PH_POLLING;
                            end
                        end else begin
                            cd_next = dec;
                            if (dec == '0) begin
                                if (ph_reg == PH_KNOWN_WAIT) begin
                                    deact = 1;
                                    q_next[0] = OP_REMOVE_ACT; q_next[1] = OP_SELECT;
                                    q_next[2] = OP_READ_ACT; qn_next = 2'd3;
                                end else begin
                                    q_next[0] = OP_NEW_TIMEOUT; qn_next = 2'd1;
                                end
                                cd_next = pticks_reg; ph_next = PH_POLLING;
                            end
                        end
                    end
                    PH_TX_WAIT: begin
                        tt_next = tinc;
                        if (tdone || tinc > txlim_reg) begin
                            q_next[0] = OP_SELECT; qn_next = 2'd1;
                            cd_next = pticks_reg; ph_next = PH_POLLING;
                        end
                    end
                    default: ph_next = PH_STARTUP;
                endcase
                out_next = {4'd0, ph_next, deact, act, rc, rv, sc, sv, pb, pv};
                st_next = C_GO;
            end
            C_GO: begin
                if (qn_reg == '0) st_next = C_OUT;
                else if (!status.busy) begin
                    cmd.op = q_reg[0];
                    q_next[0] = q_reg[1]; q_next[1] = q_reg[2]; q_next[2] = OP_NONE;
                    qn_next = qn_reg - 2'd1;
                    st_next = C_WAIT;
                end
            end
            C_WAIT: if (!status.busy) st_next = C_GO;
            C_OUT: if (m_tready) st_next = C_IDLE;
            default: st_next = C_IDLE;
        endcase
    end
    assign m_tdata = out_reg;
endmodule

// ----- hw/rtl/cab_bus_poll_scheduler_top.sv -----
`timescale 1ns / 1ps
// Channel | Direction | Content
// s_      | in        | tdata: response_received, transmit_done, pending_mask
// m_      | out       | tdata: poll_valid..bus_phase, one per input transaction
// cfg_    | in        | register writes: 0 poll_ticks, 1 transmit_limit
// A timeout of a known cab shifts the active list and searches the inactive
// list one entry a cycle. After reset a clearing pass fills the lists; no input
// transaction is accepted during it. A stalled output holds the input side.
module cab_bus_poll_scheduler_top import cbps_pkg::*; #(
    parameter int NUM_CABS = NUM_CABS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // response_received, transmit_done, pending_mask[63:0], zero fill
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // poll_valid, poll_byte, send_valid, send_cab, response_valid,
    // response_cab, activated, deactivated, bus_phase, zero fill
    output logic [31:0] m_tdata
);
`include "cab_bus_poll_scheduler_top_assert.svh"
    dp_cmd_t cmd;
    dp_status_t status;
    logic clr_new;

    cbps_controller u_ctrl (
        .aclk, .aresetn, .cfg_we, .cfg_addr, .cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata(s_tdata[65:0]),
        .m_tvalid, .m_tready, .m_tdata, .cmd, .clr_new, .status
    );
    cbps_datapath #(.NUM_CABS(NUM_CABS)) u_dp (
        .aclk, .aresetn, .cmd, .clr_new, .status
    );

    `CBPS_ASSERT_IMPL(a_no_both, aclk, aresetn, !(s_tready && m_tvalid), "both sides open")
    `CBPS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "output dropped")
endmodule
